/* rtl/core/dsv_pkg.sv */
// ----------------------------------------------------------------------------
// dsv_pkg
// shared types, constants and character classes of the decimal string validator
// ----------------------------------------------------------------------------
package dsv_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAG_W      = VALUE_BITS;
  localparam int PROD_W     = MAG_W + 4;
  localparam int OUT_W      = 32;

  localparam logic [MAG_W-1:0] NEG_LIMIT = {1'b1, {(MAG_W-1){1'b0}}};
  localparam logic [MAG_W-1:0] POS_LIMIT = NEG_LIMIT - MAG_W'(1);

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGN   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_TRAIL  = 3'd3,
    PH_BAD    = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] character;
    logic       terminator;
  } item_t;

  typedef struct packed {
    logic             valid_res;
    logic [OUT_W-1:0] value;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

endpackage

/* rtl/core/dsv_ifs.sv */
// ----------------------------------------------------------------------------
// dsv_ifs
// valid/ready channels for characters in and results out
// ----------------------------------------------------------------------------
interface dsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       terminator;

  modport source (output valid, output character, output terminator, input ready);
  modport sink   (input valid, input character, input terminator, output ready);
endinterface

interface dsv_out_if;
  logic                      valid;
  logic                      ready;
  logic                      valid_res;
  logic [dsv_pkg::OUT_W-1:0] value;

  modport source (output valid, output valid_res, output value, input ready);
  modport sink   (input valid, input valid_res, input value, output ready);
endinterface

/* rtl/core/dsv_in_reg.sv */
// ----------------------------------------------------------------------------
// dsv_in_reg
// input register, holds one character item until the parser takes it
// ----------------------------------------------------------------------------
module dsv_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  dsv_in_if.sink         in_s,
  input  logic           take,
  output logic           item_valid,
  output dsv_pkg::item_t item
);

  logic           valid_r;
  logic           valid_nxt;
  dsv_pkg::item_t item_r;
  logic           load;

  assign in_s.ready = !valid_r || take;
  assign load       = in_s.valid && in_s.ready;
  assign valid_nxt  = load ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.character  <= in_s.character;
      item_r.terminator <= in_s.terminator;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* rtl/core/dsv_parser.sv */
// ----------------------------------------------------------------------------
// dsv_parser
// parse state and per-character update, final check on the terminator
// ----------------------------------------------------------------------------
module dsv_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           take,
  input  dsv_pkg::item_t item,
  output dsv_pkg::res_t  res
);

  dsv_pkg::phase_t            phase_r, phase_nxt;
  logic                       negative_r, negative_nxt;
  logic [dsv_pkg::MAG_W-1:0]  magnitude_r, magnitude_nxt;
  logic                       overflowed_r, overflowed_nxt;

  logic [dsv_pkg::PROD_W-1:0] prod;
  logic [dsv_pkg::PROD_W-1:0] limit_ext;
  logic [3:0]                 digit;
  logic                       add_ovf;
  logic                       ch_space;
  logic                       ch_digit;
  logic                       ok;
  logic [dsv_pkg::MAG_W-1:0]  signed_mag;

  assign ch_space  = dsv_pkg::is_space(item.character);
  assign ch_digit  = dsv_pkg::is_digit(item.character);
  assign digit     = item.character[3:0];
  assign prod      = {1'b0, magnitude_r, 3'b000} + {3'b000, magnitude_r, 1'b0}
                   + dsv_pkg::PROD_W'(digit);
  assign limit_ext = dsv_pkg::PROD_W'(dsv_pkg::NEG_LIMIT);
  assign add_ovf   = prod > limit_ext;

  always_comb begin
    phase_nxt      = phase_r;
    negative_nxt   = negative_r;
    magnitude_nxt  = magnitude_r;
    overflowed_nxt = overflowed_r;
    if (item.terminator) begin
      phase_nxt      = dsv_pkg::PH_LEAD;
      negative_nxt   = 1'b0;
      magnitude_nxt  = '0;
      overflowed_nxt = 1'b0;
    end else begin
      case (phase_r)
        dsv_pkg::PH_LEAD: begin
          if (ch_space) begin
            phase_nxt = dsv_pkg::PH_LEAD;
          end else if (item.character == dsv_pkg::CH_MINUS) begin
            negative_nxt = 1'b1;
            phase_nxt    = dsv_pkg::PH_SIGN;
          end else if (item.character == dsv_pkg::CH_PLUS) begin
            phase_nxt = dsv_pkg::PH_SIGN;
          end else if (ch_digit) begin
            phase_nxt = dsv_pkg::PH_DIGITS;
          end else begin
            phase_nxt = dsv_pkg::PH_BAD;
          end
        end
        dsv_pkg::PH_SIGN: begin
          phase_nxt = ch_digit ? dsv_pkg::PH_DIGITS : dsv_pkg::PH_BAD;
        end
        dsv_pkg::PH_DIGITS: begin
          if (ch_digit) begin
            phase_nxt = dsv_pkg::PH_DIGITS;
          end else if (ch_space) begin
            phase_nxt = dsv_pkg::PH_TRAIL;
          end else begin
            phase_nxt = dsv_pkg::PH_BAD;
          end
        end
        dsv_pkg::PH_TRAIL: begin
          phase_nxt = ch_space ? dsv_pkg::PH_TRAIL : dsv_pkg::PH_BAD;
        end
        default: begin
          phase_nxt = dsv_pkg::PH_BAD;
        end
      endcase
      // digit accumulate, magnitude holds once it would pass the limit
      if (ch_digit && !overflowed_r && (phase_r == dsv_pkg::PH_LEAD ||
          phase_r == dsv_pkg::PH_SIGN || phase_r == dsv_pkg::PH_DIGITS)) begin
        if (add_ovf) begin
          overflowed_nxt = 1'b1;
        end else begin
          magnitude_nxt = prod[dsv_pkg::MAG_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= dsv_pkg::PH_LEAD;
      negative_r   <= 1'b0;
      magnitude_r  <= '0;
      overflowed_r <= 1'b0;
    end else if (take) begin
      phase_r      <= phase_nxt;
      negative_r   <= negative_nxt;
      magnitude_r  <= magnitude_nxt;
      overflowed_r <= overflowed_nxt;
    end
  end

  always_comb begin
    ok = ((phase_r == dsv_pkg::PH_DIGITS) || (phase_r == dsv_pkg::PH_TRAIL))
         && !overflowed_r
         && (negative_r ? (magnitude_r <= dsv_pkg::NEG_LIMIT)
                        : (magnitude_r <= dsv_pkg::POS_LIMIT));
    signed_mag    = negative_r ? (dsv_pkg::MAG_W'(0) - magnitude_r) : magnitude_r;
    res.valid_res = ok;
    res.value     = ok ? dsv_pkg::OUT_W'(signed_mag) : '0;
  end

endmodule

/* rtl/core/dsv_out_reg.sv */
// ----------------------------------------------------------------------------
// dsv_out_reg
// result register, holds one result item until the sink takes it
// ----------------------------------------------------------------------------
module dsv_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  dsv_pkg::res_t res,
  output logic          free,
  dsv_out_if.source     out_m
);

  logic          valid_r;
  logic          valid_nxt;
  dsv_pkg::res_t res_r;

  assign free      = !valid_r || out_m.ready;
  assign valid_nxt = load ? 1'b1 : (out_m.ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_m.valid     = valid_r;
  assign out_m.valid_res = res_r.valid_res;
  assign out_m.value     = res_r.value;

endmodule

/* rtl/core/decimal_int32_string_validator.sv */
// ----------------------------------------------------------------------------
// decimal_int32_string_validator
// checks a character stream for a well-formed int32 decimal and returns it
// ----------------------------------------------------------------------------
// channel  direction  payload                  handshake
// in_s     in         character, terminator    valid/ready
// out_m    out        valid_res, value         valid/ready
//
// one item per cycle sustained while no terminator waits; an item passes
// through the input register before the parse state and, on a terminator,
// the result register. a terminator waits in the input register only
// while the result register is full and not being taken; characters never
// wait on the output side. rst_n is synchronous: parse state back to
// leading whitespace, both registers empty.
// ----------------------------------------------------------------------------
module decimal_int32_string_validator (
  input  logic       clk,
  input  logic       rst_n,
  dsv_in_if.sink     in_s,
  dsv_out_if.source  out_m
);

  logic           item_valid;
  dsv_pkg::item_t item;
  dsv_pkg::res_t  res;
  logic           out_free;
  logic           take;

  assign take = item_valid && (!item.terminator || out_free);

  dsv_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_s       (in_s),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  dsv_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (item),
    .res   (res)
  );

  dsv_out_reg u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (take && item.terminator),
    .res   (res),
    .free  (out_free),
    .out_m (out_m)
  );

endmodule

/* tb/sv/dsv_parse_checker.sv */
// ----------------------------------------------------------------------------
// dsv_parse_checker
// watches both channels of the decimal string validator, parses each accepted
// character itself and compares every result with the predicted one
// ----------------------------------------------------------------------------
module dsv_parse_checker
  import dsv_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  dsv_in_if    in_mon,
  dsv_out_if   out_mon,
  output int   fail_count,
  output int   pending_count,
  output int   checked_count,
  output int   accepted_count
);
  timeunit 1ns;
  timeprecision 1ps;

  phase_t           scan_phase;
  logic             minus_seen;
  logic [MAG_W-1:0] digits_mag;
  logic             mag_overflow;

  res_t pending_values[$];
  int   fails    = 0;
  int   checked  = 0;
  int   accepted = 0;
  int   waiting  = 0;

  assign fail_count     = fails;
  assign pending_count  = waiting;
  assign checked_count  = checked;
  assign accepted_count = accepted;

  function automatic logic blank_char(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic decimal_char(input logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function void clear_scan();
    scan_phase   = PH_LEAD;
    minus_seen   = 1'b0;
    digits_mag   = '0;
    mag_overflow = 1'b0;
  endfunction

  function void accumulate(input logic [7:0] c);
    longint unsigned d;
    longint unsigned lim;
    d   = longint'(c) - 48;
    lim = longint'(NEG_LIMIT);
    if (!mag_overflow) begin
      if (longint'(digits_mag) > (lim - d) / 10) mag_overflow = 1'b1;
      else digits_mag = MAG_W'(longint'(digits_mag) * 10 + d);
    end
  endfunction

  function void scan_char(input logic [7:0] c);
    case (scan_phase)
      PH_LEAD: begin
        if (blank_char(c)) begin
        end else if (c == CH_MINUS) begin
          minus_seen = 1'b1;
          scan_phase = PH_SIGN;
        end else if (c == CH_PLUS) begin
          scan_phase = PH_SIGN;
        end else if (decimal_char(c)) begin
          accumulate(c);
          scan_phase = PH_DIGITS;
        end else begin
          scan_phase = PH_BAD;
        end
      end
      PH_SIGN: begin
        if (decimal_char(c)) begin
          accumulate(c);
          scan_phase = PH_DIGITS;
        end else begin
          scan_phase = PH_BAD;
        end
      end
      PH_DIGITS: begin
        if (decimal_char(c)) accumulate(c);
        else if (blank_char(c)) scan_phase = PH_TRAIL;
        else scan_phase = PH_BAD;
      end
      PH_TRAIL: begin
        if (!blank_char(c)) scan_phase = PH_BAD;
      end
      default: scan_phase = PH_BAD;
    endcase
  endfunction

  function res_t close_string();
    res_t r;
    logic ok;
    ok = (scan_phase == PH_DIGITS || scan_phase == PH_TRAIL) && !mag_overflow;
    if (ok) ok = minus_seen ? (digits_mag <= NEG_LIMIT) : (digits_mag <= POS_LIMIT);
    r.valid_res = ok;
    r.value     = ok ? (minus_seen ? OUT_W'(-digits_mag) : OUT_W'(digits_mag)) : '0;
    clear_scan();
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      clear_scan();
      pending_values.delete();
      waiting <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        checked++;
        if (pending_values.size() == 0) begin
          fails++;
          $display("%0t: unexpected result valid_res=%0b value=%0d", $time,
                   out_mon.valid_res, $signed(out_mon.value));
        end else begin
          want = pending_values.pop_front();
          if (want.valid_res)
            accepted++;
          if (out_mon.valid_res !== want.valid_res) begin
            fails++;
            $display("%0t: valid_res mismatch expected %0b actual %0b", $time,
                     want.valid_res, out_mon.valid_res);
          end
          if (out_mon.value !== want.value) begin
            fails++;
            $display("%0t: value mismatch expected %0d actual %0d", $time,
                     $signed(want.value), $signed(out_mon.value));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.terminator) pending_values.push_back(close_string());
        else scan_char(in_mon.character);
      end
      waiting <= pending_values.size();
    end
  end

endmodule

/* tb/sv/tb_decimal_int32_string_validator.sv */
// ----------------------------------------------------------------------------
// tb_decimal_int32_string_validator
// drives directed and random character strings into the validator with random
// gaps and output stalls, including a long output hold-off, and reports the
// verdict from the parse checker
// ----------------------------------------------------------------------------
module tb_decimal_int32_string_validator;
  timeunit 1ns;
  timeprecision 1ps;
  import dsv_pkg::*;

  localparam int ITEM_GOAL   = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic [7:0] chars_t[$];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic steady = 1'b0;
  logic hold_out = 1'b0;
  int   hold_count = 0;
  int   cycles = 0;
  int   items_sent = 0;
  int   strings_sent = 0;
  int   fail_count;
  int   pending_count;
  int   checked_count;
  int   accepted_count;

  dsv_in_if  in_ch();
  dsv_out_if out_ch();

  decimal_int32_string_validator uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_m (out_ch)
  );

  dsv_parse_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count),
    .accepted_count (accepted_count)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_decimal_int32_string_validator: FAIL");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_out && hold_count < HOLD_CYCLES) begin
      out_ch.ready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 10);
    end
  end

  task automatic push_item(input logic [7:0] ch, input logic term);
    if (!steady && $urandom_range(0, 99) < 10) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.character  <= ch;
    in_ch.terminator <= term;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_string(input chars_t s);
    foreach (s[i]) push_item(s[i], 1'b0);
    push_item(8'($urandom_range(0, 255)), 1'b1);
    strings_sent++;
  endtask

  task automatic send_text(input string t);
    chars_t s;
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
    send_string(s);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_blank();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
  endfunction

  function automatic chars_t well_formed();
    chars_t s;
    string digits;
    longint unsigned m;
    repeat ($urandom_range(0, 3)) s.push_back(pick_blank());
    case ($urandom_range(0, 2))
      1: s.push_back(CH_PLUS);
      2: s.push_back(CH_MINUS);
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: m = $urandom_range(0, 9);
      1: m = $urandom_range(0, 99999);
      2: m = $urandom();
      3: m = 64'd2147483643 + $urandom_range(0, 9);
      4: m = {$urandom(), $urandom()} % 64'd100000000000000;
      default: m = $urandom_range(0, 1000);
    endcase
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 12)) s.push_back(CH_ZERO);
    digits = $sformatf("%0d", m);
    for (int i = 0; i < digits.len(); i++) s.push_back(digits[i]);
    repeat ($urandom_range(0, 2)) s.push_back(pick_blank());
    return s;
  endfunction

  function automatic chars_t broken();
    chars_t s;
    s = well_formed();
    case ($urandom_range(0, 4))
      0: s.insert($urandom_range(0, s.size()), 8'($urandom_range(0, 255)));
      1: s.insert($urandom_range(0, s.size()), $urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      2: begin
        s.push_back(pick_blank());
        s.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      3: begin
        s.delete();
        repeat ($urandom_range(0, 2)) s.push_back(pick_blank());
        s.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        repeat ($urandom_range(0, 2)) s.push_back(pick_blank());
      end
      default: begin
        s.delete();
        repeat ($urandom_range(0, 4)) s.push_back(pick_blank());
      end
    endcase
    return s;
  endfunction

  function automatic chars_t noise();
    chars_t s;
    string mix;
    mix = "+-0123456789 ";
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 1)) s.push_back(8'($urandom_range(0, 255)));
      else s.push_back(mix[$urandom_range(0, mix.len() - 1)]);
    end
    return s;
  endfunction

  task automatic send_random();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) send_string(well_formed());
    else if (pick < 85) send_string(broken());
    else send_string(noise());
  endtask

  initial begin
    chars_t none;
    in_ch.valid      = 1'b0;
    in_ch.character  = '0;
    in_ch.terminator = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty, blank, most negative, space after sign, bad codes
    send_string(none);
    send_text("\t ");
    send_text("-2147483648");
    send_text("+ 7");
    send_string({8'hff});
    send_string({CH_ZERO + 8'd5, 8'h00});

    drain();

    // long output hold-off while strings keep coming
    hold_out <= 1'b1;
    repeat (40) send_random();

    steady <= 1'b1;
    repeat (120) send_random();
    steady <= 1'b0;

    while (items_sent < ITEM_GOAL) send_random();

    drain();
    repeat (16) @(posedge clk);

    $display("strings sent %0d (%0d items), results checked %0d, %0d of them well formed",
             strings_sent, items_sent, checked_count, accepted_count);
    if (fail_count == 0) begin
      $display("tb_decimal_int32_string_validator: PASS");
    end else begin
      $display("tb_decimal_int32_string_validator: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/dsv_pkg.sv
rtl/core/dsv_ifs.sv
rtl/core/dsv_in_reg.sv
rtl/core/dsv_parser.sv
rtl/core/dsv_out_reg.sv
rtl/core/decimal_int32_string_validator.sv
tb/sv/dsv_parse_checker.sv
tb/sv/tb_decimal_int32_string_validator.sv
